>>> src/lvb_pkg.sv
// Package for the look-at view basis block: shared types, pipeline depths
// and the saturation helper. No dependencies.
package lvb_pkg;

  typedef logic signed [31:0] word_t;
  typedef word_t [2:0] vec3_t;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  // Front end (abs, shift search, shift, squares, sum), root, divide, sign stage.
  localparam int NORM_LAT   = 5 + SQRT_STEPS + DIV_STEPS + 1;
  localparam int CROSS_LAT  = 2;
  localparam int TOTAL_LAT  = NORM_LAT + 2 * CROSS_LAT;

  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] UNIT     = 32'sh4000_0000;

  // Clamp a 34-bit signed value into 32 bits.
  function automatic word_t sat34(input logic signed [33:0] v);
    word_t r;
    if (v > 34'sh0_7fff_ffff) begin
      r = WORD_MAX;
    end else if (v < -34'sh0_8000_0000) begin
      r = WORD_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> src/look_at_view_basis.sv
// Top level of the look-at view basis block: two normalizer pipelines, two
// cross-product stages and the matching delay lines. Depends on lvb_pkg,
// lvb_norm and lvb_cross.
//
// Usage: raise start with eye, direction and up vectors (Q16.16) on the in_
// ports; the item is taken at that clock edge, since busy is always low.
// A new item may be started in every cycle.
// The result appears on the out_ ports for exactly one cycle with out_valid
// high, after normalization (five front-end stages, 32 root stages, 31 divide
// stages and a sign stage) and then the product and rounding stages of each
// cross product. Throughput is one item per cycle.
// side and true_up are Q2.30, back is the negated unit direction in Q2.30,
// shift is the negated eye, saturated, in Q16.16.
// The receiver cannot stall; results are only strobed and never held.
// Reset clears every valid bit, so no result appears from items in flight.
module look_at_view_basis import lvb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_eye_x,
  input  logic [31:0] in_eye_y,
  input  logic [31:0] in_eye_z,
  input  logic [31:0] in_dir_x,
  input  logic [31:0] in_dir_y,
  input  logic [31:0] in_dir_z,
  input  logic [31:0] in_up_x,
  input  logic [31:0] in_up_y,
  input  logic [31:0] in_up_z,
  output logic        out_valid,
  output logic [31:0] out_side_x,
  output logic [31:0] out_side_y,
  output logic [31:0] out_side_z,
  output logic [31:0] out_true_up_x,
  output logic [31:0] out_true_up_y,
  output logic [31:0] out_true_up_z,
  output logic [31:0] out_back_x,
  output logic [31:0] out_back_y,
  output logic [31:0] out_back_z,
  output logic [31:0] out_shift_x,
  output logic [31:0] out_shift_y,
  output logic [31:0] out_shift_z
);

  vec3_t dir_in, up_in, f, u, side, tup;
  logic  f_valid, u_valid, side_valid, tup_valid;
  logic  accept;

  vec3_t f_d1_r, f_d2_r, back_d3_r, back_d4_r;
  vec3_t side_d1_r, side_d2_r;
  vec3_t shift_r [TOTAL_LAT];
  vec3_t shift_nxt, back_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign dir_in = {in_dir_z, in_dir_y, in_dir_x};
  assign up_in  = {in_up_z, in_up_y, in_up_x};

  lvb_norm u_norm_dir (
    .clk(clk), .rst_n(rst_n), .in_valid(accept), .in_vec(dir_in),
    .out_valid(f_valid), .out_vec(f)
  );

  lvb_norm u_norm_up (
    .clk(clk), .rst_n(rst_n), .in_valid(accept), .in_vec(up_in),
    .out_valid(u_valid), .out_vec(u)
  );

  lvb_cross u_cross_side (
    .clk(clk), .rst_n(rst_n), .in_valid(f_valid && u_valid), .in_a(f), .in_b(u),
    .out_valid(side_valid), .out_vec(side)
  );

  lvb_cross u_cross_up (
    .clk(clk), .rst_n(rst_n), .in_valid(side_valid), .in_a(side), .in_b(f_d2_r),
    .out_valid(tup_valid), .out_vec(tup)
  );

  // Negating a normalized value never leaves 32 bits; the eye can.
  always_comb begin
    logic [31:0] e [3];
    e[0] = in_eye_x;
    e[1] = in_eye_y;
    e[2] = in_eye_z;
    for (int i = 0; i < 3; i++) begin
      shift_nxt[i] = ($signed(e[i]) == WORD_MIN) ? WORD_MAX : (32'd0 - e[i]);
      back_nxt[i]  = 32'd0 - f_d2_r[i];
    end
  end

  always_ff @(posedge clk) begin
    f_d1_r    <= f;
    f_d2_r    <= f_d1_r;
    back_d3_r <= back_nxt;
    back_d4_r <= back_d3_r;
    side_d1_r <= side;
    side_d2_r <= side_d1_r;
    shift_r[0] <= shift_nxt;
    for (int j = 1; j < TOTAL_LAT; j++) shift_r[j] <= shift_r[j - 1];
  end

  assign out_valid     = tup_valid;
  assign out_side_x    = side_d2_r[0];
  assign out_side_y    = side_d2_r[1];
  assign out_side_z    = side_d2_r[2];
  assign out_true_up_x = tup[0];
  assign out_true_up_y = tup[1];
  assign out_true_up_z = tup[2];
  assign out_back_x    = back_d4_r[0];
  assign out_back_y    = back_d4_r[1];
  assign out_back_z    = back_d4_r[2];
  assign out_shift_x   = shift_r[TOTAL_LAT - 1][0];
  assign out_shift_y   = shift_r[TOTAL_LAT - 1][1];
  assign out_shift_z   = shift_r[TOTAL_LAT - 1][2];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, TOTAL_LAT))
    else $error("result without a matching item");
  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid == u_valid)
    else $error("normalizer lanes out of step");
  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_back_x == 32'd0 && out_back_y == 32'd0 && out_back_z == 32'd0)
    |-> (out_side_x == 32'd0 && out_side_y == 32'd0 && out_side_z == 32'd0))
    else $error("side nonzero for zero direction");

endmodule

>>> src/lvb_norm.sv
// Normalizes one Q16.16 vector to Q2.30 through a fixed-depth pipeline:
// abs and max, shift search, shift, squares, sum, bitwise root, long divide, sign.
// Depends on lvb_pkg.
module lvb_norm import lvb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  vec3_t in_vec,
  output logic  out_valid,
  output vec3_t out_vec
);

  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [31:0] a1_r [3];
  logic [31:0] a2_r [3];
  logic [31:0] a3_r [3];
  logic [31:0] a4_r [3];
  logic [31:0] a5_r [3];
  logic [2:0]  neg1_r, neg2_r, neg3_r, neg4_r, neg5_r;
  logic [31:0] m1_r;
  logic        z2_r, z3_r, z4_r, z5_r;
  logic [4:0]  k2_r;
  logic [63:0] sq4_r [3];
  logic [63:0] s5_r;

  logic [31:0] a1_nxt [3];
  logic [31:0] m1_nxt;
  logic [4:0]  k2_nxt;

  // Root stages.
  logic        sq_v_r   [SQRT_STEPS];
  logic [63:0] sq_s_r   [SQRT_STEPS];
  logic [63:0] sq_res_r [SQRT_STEPS];
  logic [31:0] sq_a_r   [SQRT_STEPS][3];
  logic [2:0]  sq_neg_r [SQRT_STEPS];
  logic        sq_z_r   [SQRT_STEPS];
  logic [63:0] sq_s_nxt   [SQRT_STEPS];
  logic [63:0] sq_res_nxt [SQRT_STEPS];

  // Divide stages, one quotient bit per stage.
  logic        dv_v_r   [DIV_STEPS];
  logic [31:0] dv_mag_r [DIV_STEPS];
  logic [63:0] dv_rem_r [DIV_STEPS][3];
  logic [30:0] dv_q_r   [DIV_STEPS][3];
  logic [2:0]  dv_neg_r [DIV_STEPS];
  logic        dv_z_r   [DIV_STEPS];
  logic [63:0] dv_rem_nxt [DIV_STEPS][3];
  logic [30:0] dv_q_nxt   [DIV_STEPS][3];

  logic  o_v_r;
  vec3_t o_vec_r, o_vec_nxt;

  always_comb begin
    logic [32:0] t;
    m1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      t = in_vec[i][31] ? (33'd0 - {in_vec[i][31], in_vec[i]}) : {1'b0, in_vec[i]};
      a1_nxt[i] = t[31:0];
      if (a1_nxt[i] > m1_nxt) m1_nxt = a1_nxt[i];
    end
  end

  // Smallest shift that lifts the largest magnitude to at least 2^30.
  always_comb begin
    k2_nxt = '0;
    for (int i = 0; i < 30; i++) begin
      if (m1_r[i]) k2_nxt = 5'(30 - i);
    end
    if (m1_r[31] || m1_r[30]) k2_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a1_r[i]   <= a1_nxt[i];
      neg1_r[i] <= in_vec[i][31];
      a2_r[i]   <= a1_r[i];
      a3_r[i]   <= a2_r[i] << k2_r;
      a4_r[i]   <= a3_r[i];
      sq4_r[i]  <= a3_r[i] * a3_r[i];
      a5_r[i]   <= a4_r[i];
    end
    m1_r   <= m1_nxt;
    neg2_r <= neg1_r;
    neg3_r <= neg2_r;
    neg4_r <= neg3_r;
    neg5_r <= neg4_r;
    k2_r   <= k2_nxt;
    z2_r   <= (m1_r == 32'd0);
    z3_r   <= z2_r;
    z4_r   <= z3_r;
    z5_r   <= z4_r;
    s5_r   <= sq4_r[0] + sq4_r[1] + sq4_r[2];
  end

  always_comb begin
    logic [63:0] s_in, res_in, bitv, trial;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      s_in   = (j == 0) ? s5_r : sq_s_r[(j == 0) ? 0 : j - 1];
      res_in = (j == 0) ? 64'd0 : sq_res_r[(j == 0) ? 0 : j - 1];
      bitv   = 64'd1 << (62 - 2 * j);
      trial  = res_in + bitv;
      if (s_in >= trial) begin
        sq_s_nxt[j]   = s_in - trial;
        sq_res_nxt[j] = (res_in >> 1) + bitv;
      end else begin
        sq_s_nxt[j]   = s_in;
        sq_res_nxt[j] = res_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < SQRT_STEPS; j++) sq_v_r[j] <= 1'b0;
    end else begin
      sq_v_r[0] <= v5_r;
      for (int j = 1; j < SQRT_STEPS; j++) sq_v_r[j] <= sq_v_r[j - 1];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SQRT_STEPS; j++) begin
      sq_s_r[j]   <= sq_s_nxt[j];
      sq_res_r[j] <= sq_res_nxt[j];
    end
    sq_neg_r[0] <= neg5_r;
    sq_z_r[0]   <= z5_r;
    for (int i = 0; i < 3; i++) sq_a_r[0][i] <= a5_r[i];
    for (int j = 1; j < SQRT_STEPS; j++) begin
      sq_neg_r[j] <= sq_neg_r[j - 1];
      sq_z_r[j]   <= sq_z_r[j - 1];
      for (int i = 0; i < 3; i++) sq_a_r[j][i] <= sq_a_r[j - 1][i];
    end
  end

  // Restoring divide of (a << 30) by the root; the quotient never exceeds 2^30.
  always_comb begin
    logic [63:0] rem_in, dsh;
    logic [30:0] q_in;
    logic [31:0] mag;
    for (int j = 0; j < DIV_STEPS; j++) begin
      mag = (j == 0) ? sq_res_r[SQRT_STEPS - 1][31:0] : dv_mag_r[(j == 0) ? 0 : j - 1];
      dsh = {32'd0, mag} << (30 - j);
      for (int i = 0; i < 3; i++) begin
        rem_in = (j == 0) ? {2'b00, sq_a_r[SQRT_STEPS - 1][i], 30'd0}
                          : dv_rem_r[(j == 0) ? 0 : j - 1][i];
        q_in   = (j == 0) ? 31'd0 : dv_q_r[(j == 0) ? 0 : j - 1][i];
        if (rem_in >= dsh) begin
          dv_rem_nxt[j][i] = rem_in - dsh;
          dv_q_nxt[j][i]   = {q_in[29:0], 1'b1};
        end else begin
          dv_rem_nxt[j][i] = rem_in;
          dv_q_nxt[j][i]   = {q_in[29:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_STEPS; j++) dv_v_r[j] <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      dv_v_r[0] <= sq_v_r[SQRT_STEPS - 1];
      for (int j = 1; j < DIV_STEPS; j++) dv_v_r[j] <= dv_v_r[j - 1];
      o_v_r <= dv_v_r[DIV_STEPS - 1];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[j][i] <= dv_rem_nxt[j][i];
        dv_q_r[j][i]   <= dv_q_nxt[j][i];
      end
    end
    dv_mag_r[0] <= sq_res_r[SQRT_STEPS - 1][31:0];
    dv_neg_r[0] <= sq_neg_r[SQRT_STEPS - 1];
    dv_z_r[0]   <= sq_z_r[SQRT_STEPS - 1];
    for (int j = 1; j < DIV_STEPS; j++) begin
      dv_mag_r[j] <= dv_mag_r[j - 1];
      dv_neg_r[j] <= dv_neg_r[j - 1];
      dv_z_r[j]   <= dv_z_r[j - 1];
    end
    o_vec_r <= o_vec_nxt;
  end

  // A zero vector has no direction and stays zero.
  always_comb begin
    logic [31:0] qw;
    for (int i = 0; i < 3; i++) begin
      qw = {1'b0, dv_q_r[DIV_STEPS - 1][i]};
      if (dv_z_r[DIV_STEPS - 1]) begin
        o_vec_nxt[i] = '0;
      end else if (dv_neg_r[DIV_STEPS - 1][i]) begin
        o_vec_nxt[i] = 32'd0 - qw;
      end else begin
        o_vec_nxt[i] = qw;
      end
    end
  end

  assign out_valid = o_v_r;
  assign out_vec   = o_vec_r;

  a_unit_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_vec[0]) <= UNIT && $signed(out_vec[0]) >= -UNIT))
    else $error("normalized x beyond unit");
  a_unit_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_vec[1]) <= UNIT && $signed(out_vec[1]) >= -UNIT))
    else $error("normalized y beyond unit");
  a_unit_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_vec[2]) <= UNIT && $signed(out_vec[2]) >= -UNIT))
    else $error("normalized z beyond unit");

endmodule

>>> src/lvb_cross.sv
// Two-stage Q2.30 cross product: six products, then difference, rounding
// and saturation. Depends on lvb_pkg.
module lvb_cross import lvb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  vec3_t in_a,
  input  vec3_t in_b,
  output logic  out_valid,
  output vec3_t out_vec
);

  logic               v1_r, v2_r;
  logic signed [63:0] p_r [3];
  logic signed [63:0] q_r [3];
  vec3_t              r_r, r_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r[0] <= $signed(in_a[1]) * $signed(in_b[2]);
    q_r[0] <= $signed(in_b[1]) * $signed(in_a[2]);
    p_r[1] <= $signed(in_b[0]) * $signed(in_a[2]);
    q_r[1] <= $signed(in_a[0]) * $signed(in_b[2]);
    p_r[2] <= $signed(in_a[0]) * $signed(in_b[1]);
    q_r[2] <= $signed(in_b[0]) * $signed(in_a[1]);
    r_r    <= r_nxt;
  end

  // Round to nearest with halves up, then clamp to 32 bits.
  always_comb begin
    logic signed [63:0] d;
    logic signed [63:0] t;
    for (int i = 0; i < 3; i++) begin
      d = p_r[i] - q_r[i] + 64'sd536870912;
      t = d >>> 30;
      r_nxt[i] = sat34(t[33:0]);
    end
  end

  assign out_valid = v2_r;
  assign out_vec   = r_r;

endmodule
